>>> rtl/rc5_pulse_frame_decoder_defines.svh
// Assertion macros shared by the command queue and back-end modules.
`ifndef RC5_PULSE_FRAME_DECODER_DEFINES_SVH
`define RC5_PULSE_FRAME_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RC5PFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RC5PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rc5pfd_pkg.sv
`default_nettype none
package rc5pfd_pkg;

	// frame layout
	localparam int FRAME_BITS = 14;
	localparam int ADDR_W     = 5;
	localparam int CMD_W      = 6;
	localparam int ADDR_LSB   = 3;
	localparam int CMD_LSB    = 8;

	// pulse duration and threshold register
	localparam int               DUR_W     = 15;
	localparam logic [DUR_W-1:0] THR_RESET = 15'd1200;

	// configuration port
	localparam int             APB_AW     = 3;
	localparam int             APB_DW     = 32;
	localparam logic [APB_AW-1:0] REG_THRESHOLD = 3'd0;

	// bit counter, saturating at its all-ones value
	localparam int               CNT_W     = 4;
	localparam logic [CNT_W-1:0] CNT_MAX   = 4'hF;
	localparam logic [CNT_W-1:0] CNT_FRAME = 4'd14;

	// queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = 2;
	localparam int CQ_CNT_W = 3;

	// classified pulse word: levels plus long flags per half, and the last-word flag
	typedef struct packed {
		logic level_first;
		logic long_first;
		logic level_second;
		logic long_second;
		logic last_word;
	} half_cmd_t;

	// one decoded frame
	typedef struct packed {
		logic              start_first;
		logic              start_second;
		logic              toggle_bit;
		logic [ADDR_W-1:0] device_address;
		logic [CMD_W-1:0]  command_code;
		logic              frame_ok;
	} frame_t;

	// Manchester pairing and bit collection state
	typedef struct packed {
		logic                  first_level;
		logic                  pos;
		logic [FRAME_BITS-1:0] store;
		logic [CNT_W-1:0]      count;
	} dec_state_t;

endpackage
`default_nettype wire

>>> rtl/rc5pfd_front.sv
`default_nettype none
module rc5pfd_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rc5pfd_pkg::APB_AW-1:0]     paddr,
	input  wire logic [rc5pfd_pkg::APB_DW-1:0]     pwdata,
	output      logic [rc5pfd_pkg::APB_DW-1:0]     prdata,
	output      logic                              pready,
	// pulse words
	input  wire logic                              push,
	input  wire logic [rc5pfd_pkg::DUR_W-1:0]      duration_first,
	input  wire logic                              level_first,
	input  wire logic [rc5pfd_pkg::DUR_W-1:0]      duration_second,
	input  wire logic                              level_second,
	input  wire logic                              last_word,
	input  wire logic                              cq_full,
	output      logic                              cq_push,
	output      rc5pfd_pkg::half_cmd_t             cq_data
);

	logic [rc5pfd_pkg::DUR_W-1:0] threshold_q;
	logic                         reg_write;

	// write the threshold on the access beat
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && (paddr == rc5pfd_pkg::REG_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= rc5pfd_pkg::THR_RESET;
		end else if (reg_write) begin
			threshold_q <= pwdata[rc5pfd_pkg::DUR_W-1:0];
		end
	end

	// read back the threshold, zero elsewhere
	always_comb begin
		prdata = '0;
		if (paddr == rc5pfd_pkg::REG_THRESHOLD) begin
			prdata = {{(rc5pfd_pkg::APB_DW - rc5pfd_pkg::DUR_W){1'b0}}, threshold_q};
		end
	end

	// classify each half as one or two half-bits
	always_comb begin
		cq_data.level_first  = level_first;
		cq_data.long_first   = (duration_first >= threshold_q);
		cq_data.level_second = level_second;
		cq_data.long_second  = (duration_second >= threshold_q);
		cq_data.last_word    = last_word;
	end

	assign cq_push = push && !cq_full;

endmodule
`default_nettype wire

>>> rtl/rc5pfd_cmd_fifo.sv
`default_nettype none
`include "rc5_pulse_frame_decoder_defines.svh"
module rc5pfd_cmd_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_push,
	input  wire rc5pfd_pkg::half_cmd_t in_data,
	output      logic                  full,
	output      logic                  out_valid,
	output      rc5pfd_pkg::half_cmd_t out_data,
	input  wire logic                  out_pop
);

	localparam logic [rc5pfd_pkg::CQ_CNT_W-1:0] DepthCnt =
		rc5pfd_pkg::CQ_CNT_W'(rc5pfd_pkg::CQ_DEPTH);

	rc5pfd_pkg::half_cmd_t                mem_q [rc5pfd_pkg::CQ_DEPTH];
	logic [rc5pfd_pkg::CQ_PTR_W-1:0]      wr_ptr_q;
	logic [rc5pfd_pkg::CQ_PTR_W-1:0]      rd_ptr_q;
	logic [rc5pfd_pkg::CQ_CNT_W-1:0]      count_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign full      = (count_q == DepthCnt);
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign do_push   = in_push && !full;
	assign do_pop    = out_pop && out_valid;

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	`RC5PFD_ASSERT_NOW(a_cq_bound, clk, arst_n, 1'b1, count_q <= DepthCnt, "command queue overfilled")
	`RC5PFD_ASSERT_NEXT(a_cq_grow, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "command queue lost a beat")
	`RC5PFD_ASSERT_NEXT(a_cq_shrink, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "command queue pop miscounted")

endmodule
`default_nettype wire

>>> rtl/rc5pfd_back.sv
`default_nettype none
`include "rc5_pulse_frame_decoder_defines.svh"
module rc5pfd_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cq_valid,
	input  wire rc5pfd_pkg::half_cmd_t cq_data,
	output      logic                  cq_pop,
	output      rc5pfd_pkg::frame_t    res_data,
	output      logic                  res_empty,
	input  wire logic                  res_pop
);

	localparam int FrameBits = rc5pfd_pkg::FRAME_BITS;

	// feed one half-bit into the Manchester pairing
	function automatic rc5pfd_pkg::dec_state_t push_half_bit(rc5pfd_pkg::dec_state_t s,
	                                                         logic lvl);
		rc5pfd_pkg::dec_state_t n;
		n = s;
		if (!s.pos) begin
			n.first_level = lvl;
			n.pos         = 1'b1;
		end else begin
			n.pos = 1'b0;
			if (s.first_level != lvl) begin
				if (s.count < rc5pfd_pkg::CNT_FRAME) begin
					n.store = s.store |
						({{(FrameBits-1){1'b0}}, s.first_level} << s.count);
				end
				if (s.count != rc5pfd_pkg::CNT_MAX) begin
					n.count = s.count + 1'b1;
				end
			end
		end
		return n;
	endfunction

	localparam rc5pfd_pkg::dec_state_t StateReset = '{
		first_level: 1'b1,
		pos:         1'b1,
		store:       '0,
		count:       '0
	};

	rc5pfd_pkg::dec_state_t state_q;
	rc5pfd_pkg::dec_state_t st1, st2, st3, st4;
	rc5pfd_pkg::frame_t     frame;
	rc5pfd_pkg::frame_t     res_q [2];
	logic                   res_wr_q;
	logic                   res_rd_q;
	logic [1:0]             res_cnt_q;
	logic                   res_take;
	logic                   res_push;
	logic                   room;

	// walk the up to four half-bits of one word
	always_comb begin
		st1 = push_half_bit(state_q, cq_data.level_first);
		st2 = cq_data.long_first ? push_half_bit(st1, cq_data.level_first) : st1;
		st3 = push_half_bit(st2, cq_data.level_second);
		st4 = cq_data.long_second ? push_half_bit(st3, cq_data.level_second) : st3;
	end

	// assemble the frame from the stored bits
	always_comb begin
		frame.start_first    = st4.store[0];
		frame.start_second   = st4.store[1];
		frame.toggle_bit     = st4.store[2];
		for (int i = 0; i < rc5pfd_pkg::ADDR_W; i++) begin
			frame.device_address[rc5pfd_pkg::ADDR_W-1-i] = st4.store[rc5pfd_pkg::ADDR_LSB+i];
		end
		for (int i = 0; i < rc5pfd_pkg::CMD_W; i++) begin
			frame.command_code[rc5pfd_pkg::CMD_W-1-i] = st4.store[rc5pfd_pkg::CMD_LSB+i];
		end
		frame.frame_ok       = (st4.count == rc5pfd_pkg::CNT_FRAME);
	end

	// take a word unless it closes a frame and the result queue has no room
	assign res_take  = res_pop && !res_empty;
	assign room      = (res_cnt_q != 2'd2) || res_take;
	assign cq_pop    = cq_valid && (!cq_data.last_word || room);
	assign res_push  = cq_pop && cq_data.last_word;
	assign res_empty = (res_cnt_q == 2'd0);
	assign res_data  = res_q[res_rd_q];

	// update decoder state, clear it after the closing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (cq_pop) begin
			state_q <= cq_data.last_word ? StateReset : st4;
		end
	end

	// advance the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_take) begin
				res_rd_q <= !res_rd_q;
			end
			if (res_push && !res_take) begin
				res_cnt_q <= res_cnt_q + 2'd1;
			end else if (res_take && !res_push) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	// hold the finished frame
	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= frame;
		end
	end

	`RC5PFD_ASSERT_NOW(a_res_bound, clk, arst_n, 1'b1, res_cnt_q <= 2'd2, "result queue overfilled")
	`RC5PFD_ASSERT_NEXT(a_res_ready, clk, arst_n, res_push, !res_empty, "closing word produced no result")
	`RC5PFD_ASSERT_NEXT(a_clear, clk, arst_n, res_push, state_q == StateReset, "decoder not cleared after frame")

endmodule
`default_nettype wire

>>> rtl/rc5_pulse_frame_decoder.sv
`default_nettype none
// RC5 pulse frame decoder. Pulse words (two duration/level halves) are pushed
// while full is low, one per cycle; each half counts as one half-bit, or two
// when its duration is at or above the threshold register (APB address 0,
// reset 1200). Half-bits are paired into Manchester symbols and the word
// flagged last_word yields one frame on the result side: it is registered in
// the command queue, then written to the result queue once that has room,
// which lowers empty and clears the decoding state.
// A four-entry queue sits between the threshold compare and the decoder, and
// a two-entry result queue follows it, so words keep flowing at one per cycle
// while results wait; full rises only once both queues have backed up.
module rc5_pulse_frame_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rc5pfd_pkg::APB_AW-1:0]  paddr,
	input  wire logic [rc5pfd_pkg::APB_DW-1:0]  pwdata,
	output      logic [rc5pfd_pkg::APB_DW-1:0]  prdata,
	output      logic                           pready,
	// pulse words in
	input  wire logic                           push,
	output      logic                           full,
	input  wire logic [rc5pfd_pkg::DUR_W-1:0]   duration_first,
	input  wire logic                           level_first,
	input  wire logic [rc5pfd_pkg::DUR_W-1:0]   duration_second,
	input  wire logic                           level_second,
	input  wire logic                           last_word,
	// frames out
	output      logic                           empty,
	input  wire logic                           pop,
	output      logic                           start_first,
	output      logic                           start_second,
	output      logic                           toggle_bit,
	output      logic [rc5pfd_pkg::ADDR_W-1:0]  device_address,
	output      logic [rc5pfd_pkg::CMD_W-1:0]   command_code,
	output      logic                           frame_ok
);

	rc5pfd_pkg::half_cmd_t cq_in;
	rc5pfd_pkg::half_cmd_t cq_out;
	rc5pfd_pkg::frame_t    res;
	logic                  cq_push;
	logic                  cq_full;
	logic                  cq_valid;
	logic                  cq_pop;

	rc5pfd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.push            (push),
		.duration_first  (duration_first),
		.level_first     (level_first),
		.duration_second (duration_second),
		.level_second    (level_second),
		.last_word       (last_word),
		.cq_full         (cq_full),
		.cq_push         (cq_push),
		.cq_data         (cq_in)
	);

	rc5pfd_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_push   (cq_push),
		.in_data   (cq_in),
		.full      (cq_full),
		.out_valid (cq_valid),
		.out_data  (cq_out),
		.out_pop   (cq_pop)
	);

	rc5pfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_valid  (cq_valid),
		.cq_data   (cq_out),
		.cq_pop    (cq_pop),
		.res_data  (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	// present the oldest frame
	assign full           = cq_full;
	assign start_first    = res.start_first;
	assign start_second   = res.start_second;
	assign toggle_bit     = res.toggle_bit;
	assign device_address = res.device_address;
	assign command_code   = res.command_code;
	assign frame_ok       = res.frame_ok;

endmodule
`default_nettype wire
